FILE: hdl/pport_pkg.sv
`default_nettype none

package pport_pkg;

  // register select on the host bus
  typedef enum logic [1:0] {
    REG_PORT_A = 2'd0,
    REG_PORT_B = 2'd1,
    REG_PORT_C = 2'd2,
    REG_CTRL   = 2'd3
  } pport_reg_e;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } pport_kind_e;

  // group A mode codes
  localparam logic [1:0] GA_MODE_0 = 2'd0;
  localparam logic [1:0] GA_MODE_1 = 2'd1;
  localparam logic [1:0] GA_MODE_2 = 2'd2;
  localparam logic [1:0] GA_MODE_3 = 2'd3;

  // group B mode codes
  localparam logic GB_MODE_0 = 1'b0;

  // fixed bits 6..1 on a port B read
  localparam logic [5:0] PORT_B_FIXED = 6'b011111;

  typedef struct packed {
    logic       kind;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic [7:0] sound_data_in;
    logic       tape_level;
    logic       vsync;
  } pport_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sound_data_we;
    logic [7:0] sound_data_out;
    logic       row_we;
    logic [3:0] row_out;
    logic       func_we;
    logic       sound_bdir;
    logic       sound_bc1;
    logic       motor_we;
    logic       motor_on;
  } pport_out_t;

endpackage

`default_nettype wire

FILE: hdl/pport_core.sv
`default_nettype none

module pport_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        fire_i,
  input  wire pport_pkg::pport_in_t  item_i,
  output pport_pkg::pport_out_t      result_o
);
  import pport_pkg::*;

  logic [7:0] ctrl_q,     ctrl_d;
  logic [1:0] ga_mode_q,  ga_mode_d;
  logic       gb_mode_q,  gb_mode_d;
  logic [7:0] a_hs_q,     a_hs_d;
  logic [2:0] b_hs_q,     b_hs_d;
  logic [3:0] c_low_q,    c_low_d;
  logic [3:0] c_high_q,   c_high_d;
  logic       c_low_in_q,  c_low_in_d;
  logic       c_high_in_q, c_high_in_d;
  logic       a_in_q,     a_in_d;
  logic       b_in_q,     b_in_d;

  logic       do_low, do_high;
  logic [3:0] low_nib, high_nib;
  logic [2:0] bsr_bit;
  logic [3:0] bsr_mask;
  logic [3:0] rd_c_low, rd_c_high;
  logic       is_write;
  pport_reg_e sel;

  assign is_write = (item_i.kind == ACC_WRITE);
  assign sel      = pport_reg_e'(item_i.reg_sel);
  assign bsr_bit  = item_i.write_data[3:1];
  assign bsr_mask = 4'b0001 << bsr_bit[1:0];

  // port C as seen on a read
  always_comb begin
    rd_c_low  = 4'd0;
    rd_c_high = 4'd0;
    if (!c_low_in_q) begin
      rd_c_low = (gb_mode_q == GB_MODE_0) ? c_low_q : {1'b0, b_hs_q};
      if (ga_mode_q != GA_MODE_0) rd_c_low[3] = a_hs_q[3];
    end
    if (!c_high_in_q) begin
      unique case (ga_mode_q)
        GA_MODE_0:            rd_c_high = c_high_q;
        GA_MODE_1, GA_MODE_2: rd_c_high = a_hs_q[7:4];
        default:              rd_c_high = 4'd0;
      endcase
    end
  end

  // nibble updates from port C writes and bit set/reset
  always_comb begin
    do_low   = 1'b0;
    do_high  = 1'b0;
    low_nib  = c_low_q;
    high_nib = c_high_q;
    if (is_write && sel == REG_PORT_C) begin
      do_low  = !c_low_in_q;
      do_high = !c_high_in_q;
      if (do_low)  low_nib  = item_i.write_data[3:0];
      if (do_high) high_nib = item_i.write_data[7:4];
    end else if (is_write && sel == REG_CTRL && !item_i.write_data[7]) begin
      if (!bsr_bit[2]) begin
        do_low  = 1'b1;
        low_nib = item_i.write_data[0] ? (c_low_q | bsr_mask) : (c_low_q & ~bsr_mask);
      end else begin
        do_high  = 1'b1;
        high_nib = item_i.write_data[0] ? (c_high_q | bsr_mask) : (c_high_q & ~bsr_mask);
      end
    end
  end

  always_comb begin
    result_o    = '0;
    ctrl_d      = ctrl_q;
    ga_mode_d   = ga_mode_q;
    gb_mode_d   = gb_mode_q;
    a_hs_d      = a_hs_q;
    b_hs_d      = b_hs_q;
    c_low_d     = low_nib;
    c_high_d    = high_nib;
    c_low_in_d  = c_low_in_q;
    c_high_in_d = c_high_in_q;
    a_in_d      = a_in_q;
    b_in_d      = b_in_q;

    if (!is_write) begin
      unique case (sel)
        REG_PORT_A: begin
          if (a_in_q || ga_mode_q == GA_MODE_2) result_o.read_data = item_i.sound_data_in;
        end
        REG_PORT_B: begin
          if (b_in_q) result_o.read_data = {item_i.tape_level, PORT_B_FIXED, item_i.vsync};
        end
        REG_PORT_C: result_o.read_data = {rd_c_high, rd_c_low};
        default:    result_o.read_data = 8'd0;
      endcase
    end else begin
      if (sel == REG_PORT_A && (!a_in_q || ga_mode_q == GA_MODE_2)) begin
        result_o.sound_data_we  = 1'b1;
        result_o.sound_data_out = item_i.write_data;
      end
      if (sel == REG_CTRL && item_i.write_data[7]) begin
        // mode word: every output strobed to zero, flags decoded
        result_o.sound_data_we = 1'b1;
        result_o.row_we        = 1'b1;
        result_o.func_we       = 1'b1;
        result_o.motor_we      = 1'b1;
        ctrl_d      = item_i.write_data;
        ga_mode_d   = item_i.write_data[6:5];
        gb_mode_d   = item_i.write_data[2];
        c_low_in_d  = item_i.write_data[0];
        c_high_in_d = item_i.write_data[3];
        a_in_d      = item_i.write_data[4];
        b_in_d      = item_i.write_data[1];
      end
    end

    if (do_low) begin
      if (ga_mode_q != GA_MODE_0) a_hs_d[3] = low_nib[3];
      if (gb_mode_q == GB_MODE_0) begin
        result_o.row_we  = 1'b1;
        result_o.row_out = low_nib;
      end else begin
        b_hs_d = low_nib[2:0];
      end
    end

    if (do_high) begin
      unique case (ga_mode_q)
        GA_MODE_0: begin
          result_o.func_we    = 1'b1;
          result_o.sound_bdir = high_nib[3];
          result_o.sound_bc1  = high_nib[2];
          result_o.motor_we   = 1'b1;
          result_o.motor_on   = high_nib[0];
        end
        // handshake OR never clears bits
        GA_MODE_1, GA_MODE_2: a_hs_d[7:4] = a_hs_q[7:4] | high_nib;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      ga_mode_q   <= '0;
      gb_mode_q   <= 1'b0;
      a_hs_q      <= '0;
      b_hs_q      <= '0;
      c_low_q     <= '0;
      c_high_q    <= '0;
      c_low_in_q  <= 1'b0;
      c_high_in_q <= 1'b0;
      a_in_q      <= 1'b0;
      b_in_q      <= 1'b0;
    end else if (fire_i) begin
      ctrl_q      <= ctrl_d;
      ga_mode_q   <= ga_mode_d;
      gb_mode_q   <= gb_mode_d;
      a_hs_q      <= a_hs_d;
      b_hs_q      <= b_hs_d;
      c_low_q     <= c_low_d;
      c_high_q    <= c_high_d;
      c_low_in_q  <= c_low_in_d;
      c_high_in_q <= c_high_in_d;
      a_in_q      <= a_in_d;
      b_in_q      <= b_in_d;
    end
  end

`ifndef ASSERT_OFF
  a_ctrl_mode_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q == 8'd0) || ctrl_q[7])
    else $error("control byte holds a non-mode word");

  a_flags_match_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ga_mode_q == ctrl_q[6:5] && gb_mode_q == ctrl_q[2] && c_low_in_q == ctrl_q[0] &&
    c_high_in_q == ctrl_q[3] && a_in_q == ctrl_q[4] && b_in_q == ctrl_q[1])
    else $error("decoded flags disagree with control byte");

  a_func_only_mode0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && result_o.func_we && !(sel == REG_CTRL && item_i.write_data[7]))
      |-> (ga_mode_q == GA_MODE_0))
    else $error("sound function strobe outside group A mode 0");
`endif

endmodule

`default_nettype wire

FILE: hdl/parallel_port_interface_8255.sv
// Three-port parallel interface: one bus access in, one result out per request.
// Each request is registered in the input register, then its result in the result register;
// a stall on the output can hold the request between the two.
// Throughput: one request per cycle; only a stalled result register holds input.
// Reset (rst_ni low, asynchronous) empties both stages and clears all port state to zero.
`default_nettype none

module parallel_port_interface_8255 (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire pport_pkg::pport_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output pport_pkg::pport_out_t      out_data_o
);
  import pport_pkg::*;

  logic       in_vld_q, in_vld_d;
  pport_in_t  in_q;
  logic       out_vld_q, out_vld_d;
  pport_out_t out_q;
  pport_out_t result;
  logic       out_free, advance, accept;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_vld_d  = accept || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && out_stall_i);

  pport_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept)  in_q  <= in_data_i;
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed request did not reach the result register");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free result register");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pport_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  pport_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  pport_out_t out_data_o;

  parallel_port_interface_8255 i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predicted port state
  logic [7:0] ctrl_word;
  logic [1:0] ga_mode;
  logic       gb_mode;
  logic [7:0] hs_a;
  logic [2:0] hs_b;
  logic [3:0] c_lo;
  logic [3:0] c_hi;
  logic       c_lo_in, c_hi_in, a_in, b_in;

  pport_in_t  pending_accesses[$];
  pport_out_t predicted_results[$];
  pport_out_t result_want;

  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_reads = 0;
  int n_mode_words = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_style = 0;
  int stall_phase = 0;
  logic [2:0] stall_tick = '0;

  initial begin
    ctrl_word = '0; ga_mode = GA_MODE_0; gb_mode = GB_MODE_0;
    hs_a = '0; hs_b = '0; c_lo = '0; c_hi = '0;
    c_lo_in = 1'b0; c_hi_in = 1'b0; a_in = 1'b0; b_in = 1'b0;
  end

  function automatic void apply_c_low(inout pport_out_t r);
    if (ga_mode != GA_MODE_0) hs_a[3] = c_lo[3];
    if (gb_mode == GB_MODE_0) begin
      r.row_we  = 1'b1;
      r.row_out = c_lo;
    end else begin
      hs_b = c_lo[2:0];
    end
  endfunction

  function automatic void apply_c_high(inout pport_out_t r);
    if (ga_mode == GA_MODE_0) begin
      r.func_we    = 1'b1;
      r.sound_bdir = c_hi[3];
      r.sound_bc1  = c_hi[2];
      r.motor_we   = 1'b1;
      r.motor_on   = c_hi[0];
    end else if (ga_mode == GA_MODE_1 || ga_mode == GA_MODE_2) begin
      // handshake OR only ever sets bits
      hs_a[7:4] = hs_a[7:4] | c_hi;
    end
  endfunction

  function automatic pport_out_t predict_access(pport_in_t req);
    pport_out_t r;
    logic [7:0] v;
    logic [7:0] wd;
    r  = '0;
    v  = '0;
    wd = req.write_data;
    if (req.kind == ACC_READ) begin
      case (req.reg_sel)
        REG_PORT_A: if (a_in || ga_mode == GA_MODE_2) v = req.sound_data_in;
        REG_PORT_B: if (b_in) v = {req.tape_level, PORT_B_FIXED, req.vsync};
        REG_PORT_C: begin
          if (!c_lo_in) begin
            v[3:0] = (gb_mode == GB_MODE_0) ? c_lo : {1'b0, hs_b};
            if (ga_mode != GA_MODE_0) v[3] = hs_a[3];
          end
          if (!c_hi_in) begin
            if (ga_mode == GA_MODE_0) v[7:4] = c_hi;
            else if (ga_mode == GA_MODE_1 || ga_mode == GA_MODE_2) v[7:4] = hs_a[7:4];
          end
        end
        default: v = '0;
      endcase
      r.read_data = v;
      return r;
    end
    case (req.reg_sel)
      REG_PORT_A: begin
        if (!a_in || ga_mode == GA_MODE_2) begin
          r.sound_data_we  = 1'b1;
          r.sound_data_out = wd;
        end
      end
      REG_PORT_C: begin
        if (!c_lo_in) begin
          c_lo = wd[3:0];
          apply_c_low(r);
        end
        if (!c_hi_in) begin
          c_hi = wd[7:4];
          apply_c_high(r);
        end
      end
      REG_CTRL: begin
        if (wd[7]) begin
          // mode word: all strobes fire with zero data
          ctrl_word = wd;
          r.sound_data_we = 1'b1;
          r.row_we        = 1'b1;
          r.func_we       = 1'b1;
          r.motor_we      = 1'b1;
          ga_mode = wd[6:5];
          gb_mode = wd[2];
          c_lo_in = wd[0];
          c_hi_in = wd[3];
          a_in    = wd[4];
          b_in    = wd[1];
        end else if (!wd[3]) begin
          c_lo[wd[2:1]] = wd[0];
          apply_c_low(r);
        end else begin
          c_hi[wd[2:1]] = wd[0];
          apply_c_high(r);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic push_access(pport_kind_e k, pport_reg_e r, logic [7:0] wd,
                             logic [7:0] snd, logic tape, logic vs);
    pport_in_t a;
    a.kind          = k;
    a.reg_sel       = r;
    a.write_data    = wd;
    a.sound_data_in = snd;
    a.tape_level    = tape;
    a.vsync         = vs;
    pending_accesses.push_back(a);
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_results.push_back(predict_access(in_data_i));
        n_accepted++;
        if (in_data_i.kind == ACC_READ) n_reads++;
        else if (in_data_i.reg_sel == REG_CTRL && in_data_i.write_data[7]) n_mode_words++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          in_data_i  <= pending_accesses.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no request pending", 0, 0);
      end else begin
        result_want = predicted_results.pop_front();
        check_field("read_data", out_data_o.read_data, result_want.read_data);
        check_field("sound_data_we", out_data_o.sound_data_we, result_want.sound_data_we);
        check_field("sound_data_out", out_data_o.sound_data_out, result_want.sound_data_out);
        check_field("row_we", out_data_o.row_we, result_want.row_we);
        check_field("row_out", out_data_o.row_out, result_want.row_out);
        check_field("func_we", out_data_o.func_we, result_want.func_we);
        check_field("sound_bdir", out_data_o.sound_bdir, result_want.sound_bdir);
        check_field("sound_bc1", out_data_o.sound_bc1, result_want.sound_bc1);
        check_field("motor_we", out_data_o.motor_we, result_want.motor_we);
        check_field("motor_on", out_data_o.motor_on, result_want.motor_on);
        n_checked++;
      end
    end
    if (stall_phase == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_phase = $urandom_range(20, 120);
    end else begin
      stall_phase--;
    end
    stall_tick <= stall_tick + 3'd1;
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_tick >= 3'd5);
    endcase
  end

  initial begin
    int p;
    pport_kind_e k;
    // reset state, mode 0 all outputs
    push_access(ACC_READ,  REG_PORT_A, 8'h00, 8'hFF, 1'b1, 1'b1);
    push_access(ACC_READ,  REG_PORT_B, 8'h00, 8'h00, 1'b1, 1'b1);
    push_access(ACC_READ,  REG_PORT_C, 8'h00, 8'hFF, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_CTRL,   8'hFF, 8'hFF, 1'b1, 1'b1);
    push_access(ACC_WRITE, REG_PORT_A, 8'hFF, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_A, 8'h00, 8'hFF, 1'b1, 1'b1);
    push_access(ACC_WRITE, REG_PORT_C, 8'hA5, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_C, 8'h5A, 8'h00, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_C, 8'h00, 8'h00, 1'b0, 1'b0);
    // everything input
    push_access(ACC_WRITE, REG_CTRL,   8'h9B, 8'h00, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_A, 8'h00, 8'hA5, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_B, 8'h00, 8'h00, 1'b1, 1'b1);
    push_access(ACC_READ,  REG_PORT_B, 8'h00, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_A, 8'h33, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_C, 8'hFF, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_B, 8'hFF, 8'h00, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_C, 8'h00, 8'h00, 1'b0, 1'b0);
    // bit set/reset ignores direction
    push_access(ACC_WRITE, REG_CTRL,   8'h0F, 8'h00, 1'b0, 1'b0);
    // group A mode 1, group B mode 1
    push_access(ACC_WRITE, REG_CTRL,   8'hA4, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_C, 8'h3C, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_C, 8'h00, 8'h00, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_C, 8'h00, 8'h00, 1'b0, 1'b0);
    // group A mode 2: port A both ways
    push_access(ACC_WRITE, REG_CTRL,   8'hD0, 8'h00, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_A, 8'h00, 8'h5A, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_A, 8'h77, 8'h00, 1'b0, 1'b0);
    // group A mode 3
    push_access(ACC_WRITE, REG_CTRL,   8'hE0, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_PORT_C, 8'hF7, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_CTRL,   8'h06, 8'h00, 1'b0, 1'b0);
    push_access(ACC_WRITE, REG_CTRL,   8'h0E, 8'h00, 1'b0, 1'b0);
    push_access(ACC_READ,  REG_PORT_C, 8'h00, 8'h00, 1'b0, 1'b0);

    repeat (700) begin
      p = $urandom_range(0, 99);
      k = pport_kind_e'($urandom_range(0, 1));
      if (p < 8)
        push_access(ACC_WRITE, REG_CTRL, 8'h80 | 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 22)
        push_access(ACC_WRITE, REG_CTRL, 8'h7F & 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 42)
        push_access(ACC_WRITE, REG_PORT_C, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 57)
        push_access(ACC_READ, REG_PORT_C, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 67)
        push_access(ACC_WRITE, REG_PORT_A, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 75)
        push_access(ACC_READ, REG_PORT_A, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 81)
        push_access(ACC_READ, REG_PORT_B, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 85)
        push_access(ACC_WRITE, REG_PORT_B, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else if (p < 90)
        push_access(ACC_READ, REG_CTRL, 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
      else
        push_access(k, pport_reg_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_accesses.size() != 0 || in_valid_i || predicted_results.size() != 0)
      @(posedge clk_i);
    // two-stage pipe; the extra wait catches stray results
    repeat (8) @(posedge clk_i);

    $display("covered %0d bus accesses: %0d reads, %0d mode words, rest writes",
             n_accepted, n_reads, n_mode_words);
    $display("%0d results checked field by field, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("parallel_port_interface_8255: match");
    end else begin
      $display("parallel_port_interface_8255: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d requests still pending", predicted_results.size());
    $display("parallel_port_interface_8255: mismatch");
    $finish;
  end

endmodule
